// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// File: rtl/core/sha256_pkg.sv
// Types, constants and round functions for the SHA-256 hasher.
package sha256_pkg;
   localparam logic [31:0] IV [8] = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
                                       32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
   localparam logic [31:0] RK [64] = '{
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
      32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
      32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
      32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
      32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
      32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
      32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
      32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
      32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
      32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS = 6'd56;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ROUND, ST_FOLD, ST_PAD, ST_DONE
   } state_type;

   // Byte source for the datapath buffer write.
   typedef enum logic [1:0] {
      SRC_DATA, SRC_PAD, SRC_ZERO
   } src_type;

   typedef struct packed {
      logic    put;      // write one byte at fill position
      src_type src;
      logic    count;    // add one to message length
      logic    put_len;  // write bit length into words 14, 15
      logic    start;    // load working vars, round 0
      logic    round;    // one round step
      logic    fold;     // add working vars into chaining words
      logic    restart;  // return to initial state
   } cmd_type;

   typedef struct packed {
      logic       full;   // put would fill the block
      logic [5:0] fill;
      logic       last_round;
   } sts_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction
endpackage

// File: rtl/core/sha256_datapath.sv
// Block buffer, message schedule, round logic and chaining words.
`include "assert_macros.svh"
module sha256_datapath (
   input  logic                clock,
   input  logic                reset,
   input  sha256_pkg::cmd_type cmd,
   input  logic [7:0]          data_byte,
   output sha256_pkg::sts_type sts,
   output logic [255:0]        digest
);
   logic [31:0] blk_ff [16];
   logic [31:0] blk_in [16];
   logic [31:0] h_ff [8];
   logic [31:0] h_in [8];
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] len_ff, len_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [7:0]  wbyte;
   logic [31:0] w_new, wr, t1, t2, a2, a15;
   logic [63:0] bits;

   assign bits = {len_ff, 3'b000};
   assign sts.fill = fill_ff;
   assign sts.full = (fill_ff == 6'd63);
   assign sts.last_round = (rnd_ff == 6'd63);

   always_comb begin
      case (cmd.src)
         sha256_pkg::SRC_DATA: wbyte = data_byte;
         sha256_pkg::SRC_PAD:  wbyte = sha256_pkg::PAD_BYTE;
         default:              wbyte = 8'h00;
      endcase
   end

   // Schedule: blk_ff is the rolling window; entry 0 is the current word.
   assign a2  = blk_ff[14];
   assign a15 = blk_ff[1];
   assign w_new = (sha256_pkg::rotr(a2, 17) ^ sha256_pkg::rotr(a2, 19) ^ (a2 >> 10))
                + blk_ff[9] + blk_ff[0]
                + (sha256_pkg::rotr(a15, 7) ^ sha256_pkg::rotr(a15, 18) ^ (a15 >> 3));
   assign wr = blk_ff[0];

   assign t1 = v_ff[7]
             + (sha256_pkg::rotr(v_ff[4], 6) ^ sha256_pkg::rotr(v_ff[4], 11)
                ^ sha256_pkg::rotr(v_ff[4], 25))
             + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + sha256_pkg::RK[rnd_ff] + wr;
   assign t2 = (sha256_pkg::rotr(v_ff[0], 2) ^ sha256_pkg::rotr(v_ff[0], 13)
                ^ sha256_pkg::rotr(v_ff[0], 22))
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   always_comb begin
      blk_in  = blk_ff;
      h_in    = h_ff;
      v_in    = v_ff;
      fill_in = fill_ff;
      len_in  = len_ff;
      rnd_in  = rnd_ff;
      if (cmd.put) begin
         blk_in[fill_ff[5:2]][8*(3-fill_ff[1:0]) +: 8] = wbyte;
         fill_in = fill_ff + 6'd1;
      end
      if (cmd.count) len_in = len_ff + 61'd1;
      if (cmd.put_len) begin
         blk_in[14] = bits[63:32];
         blk_in[15] = bits[31:0];
      end
      if (cmd.start) begin
         v_in   = h_ff;
         rnd_in = 6'd0;
      end
      if (cmd.round) begin
         // Rotate the window; the word for round r+16 enters at the tail.
         for (int i = 0; i < 15; i++) blk_in[i] = blk_ff[i+1];
         blk_in[15] = w_new;
         for (int i = 7; i > 0; i--) v_in[i] = v_ff[i-1];
         v_in[4] = v_ff[3] + t1;
         v_in[0] = t1 + t2;
         rnd_in  = rnd_ff + 6'd1;
      end
      if (cmd.fold) begin
         for (int i = 0; i < 8; i++) h_in[i] = h_ff[i] + v_ff[i];
      end
      if (cmd.restart) begin
         h_in    = sha256_pkg::IV;
         fill_in = 6'd0;
         len_in  = 61'd0;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      v_ff   <= v_in;
      rnd_ff <= rnd_in;
      if (reset) begin
         h_ff    <= sha256_pkg::IV;
         fill_ff <= 6'd0;
         len_ff  <= 61'd0;
      end else begin
         h_ff    <= h_in;
         fill_ff <= fill_in;
         len_ff  <= len_in;
      end
   end

   for (genvar g = 0; g < 8; g++) begin : g_dig
      assign digest[255-32*g -: 32] = h_ff[g];
   end

   `ASSERT_CLK(a_round_needs_not_put, clock, reset, !(cmd.round && cmd.put), "round with put")
   `ASSERT_CLK(a_fill_wraps, clock, reset, (cmd.put && sts.full) |=> (fill_ff == 6'd0), "fill")
   `ASSERT_CLK(a_round_steps, clock, reset, (cmd.round && !sts.last_round) |=> (rnd_ff != 6'd0), "rnd")
endmodule

// File: rtl/core/sha256_ctrl.sv
// Controller state machine for byte intake, compression and padding.
`include "assert_macros.svh"
module sha256_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_fire,
   input  logic                byte_present,
   input  logic                end_of_message,
   input  logic                rsp_taken,
   input  sha256_pkg::sts_type sts,
   output sha256_pkg::cmd_type cmd,
   output logic                in_ready,
   output logic                out_valid
);
   sha256_pkg::state_type state_ff, state_in;
   logic pend_ff, pend_in;   // message end pending after current block
   logic last_ff, last_in;   // block in flight is the final one
   logic pad_ff, pad_in;     // 0x80 byte already written

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha256_pkg::ST_IDLE;
         pend_ff  <= 1'b0;
         last_ff  <= 1'b0;
         pad_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         last_ff  <= last_in;
         pad_ff   <= pad_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      pend_in   = pend_ff;
      last_in   = last_ff;
      pad_in    = pad_ff;
      cmd       = '0;
      cmd.src   = sha256_pkg::SRC_DATA;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         sha256_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (req_fire) begin
               cmd.put   = byte_present;
               cmd.count = byte_present;
               if (byte_present && sts.full) begin
                  state_in  = sha256_pkg::ST_ROUND;
                  cmd.start = 1'b1;
                  pend_in   = end_of_message;
                  last_in   = 1'b0;
                  pad_in    = 1'b0;
               end else if (end_of_message) begin
                  state_in = sha256_pkg::ST_PAD;
                  pend_in  = 1'b0;
                  pad_in   = 1'b0;
               end
            end
         end
         sha256_pkg::ST_PAD: begin
            // First pad byte is 0x80, rest zeros up to the length field.
            cmd.put = 1'b1;
            cmd.src = pad_ff ? sha256_pkg::SRC_ZERO : sha256_pkg::SRC_PAD;
            pend_in = 1'b1;
            pad_in  = 1'b1;
            if (sts.full) begin
               state_in  = sha256_pkg::ST_ROUND;
               cmd.start = 1'b1;
               last_in   = 1'b0;
            end else if (sts.fill == sha256_pkg::LEN_POS - 6'd1) begin
               state_in    = sha256_pkg::ST_ROUND;
               cmd.put_len = 1'b1;
               cmd.start   = 1'b1;
               last_in     = 1'b1;
            end
         end
         sha256_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
            if (sts.last_round) state_in = sha256_pkg::ST_FOLD;
         end
         sha256_pkg::ST_FOLD: begin
            cmd.fold = 1'b1;
            if (last_ff) state_in = sha256_pkg::ST_DONE;
            else if (pend_ff) state_in = sha256_pkg::ST_PAD;
            else state_in = sha256_pkg::ST_IDLE;
         end
         sha256_pkg::ST_DONE: begin
            out_valid = 1'b1;
            if (rsp_taken) begin
               cmd.restart = 1'b1;
               pend_in     = 1'b0;
               last_in     = 1'b0;
               pad_in      = 1'b0;
               state_in    = sha256_pkg::ST_IDLE;
            end
         end
         default: state_in = sha256_pkg::ST_IDLE;
      endcase
   end

   `ASSERT_CLK(a_no_accept_busy, clock, reset, req_fire |-> (state_ff == sha256_pkg::ST_IDLE), "busy accept")
   `ASSERT_CLK(a_out_holds, clock, reset, (out_valid && !rsp_taken) |=> out_valid, "out drop")
   `ASSERT_NEVER(a_one_cmd, clock, reset, cmd.round && cmd.fold, "round and fold")
endmodule

// File: rtl/core/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher.
// Bytes enter one per cycle while the 64-byte block fills. When the block
// is full the 64 rounds run one per cycle, then a fold step adds the
// working variables into the chaining words; req_tready is low during
// compression. On end of message, padding writes one byte per cycle and
// may need a second compression; the digest then waits on the rsp side
// until taken, after which the hasher is ready for a new message.
module sha256_byte_stream_hasher (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tuser,   // byte_present
   input  logic         req_tlast,   // end_of_message
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [255:0] rsp_tdata    // digest_part_0..3, each big-endian
);
   sha256_pkg::cmd_type cmd;
   sha256_pkg::sts_type sts;
   logic [255:0] digest;
   logic req_fire;

   assign req_fire = req_tvalid && req_tready;
   // Part 0 in the lowest 64 bits.
   assign rsp_tdata = {digest[63:0], digest[127:64], digest[191:128], digest[255:192]};

   sha256_ctrl u_ctrl (
      .clock, .reset, .req_fire,
      .byte_present(req_tuser), .end_of_message(req_tlast),
      .rsp_taken(rsp_tvalid && rsp_tready), .sts, .cmd,
      .in_ready(req_tready), .out_valid(rsp_tvalid)
   );

   sha256_datapath u_dp (
      .clock, .reset, .cmd, .data_byte(req_tdata), .sts, .digest
   );
endmodule
